[rtl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg: shared types, codes and lookup functions for the tokenizer
// Scanner modes, token kinds, keyword table and saturating counter helpers.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int KEYWORD_CHARS  = 6;
	localparam int NEST_DEPTH_MAX = 15;
	localparam int DEPTH_W        = $clog2(NEST_DEPTH_MAX + 1);
	localparam int KW_W           = 8 * KEYWORD_CHARS;
	localparam int KW_IDX_W       = $clog2(KEYWORD_CHARS);
	localparam int KW_COUNT       = 18;

	localparam logic [3:0] M_IDLE  = 4'd0;
	localparam logic [3:0] M_SLASH = 4'd1;
	localparam logic [3:0] M_LINE  = 4'd2;
	localparam logic [3:0] M_BLOCK = 4'd3;
	localparam logic [3:0] M_IDENT = 4'd4;
	localparam logic [3:0] M_INT   = 4'd5;
	localparam logic [3:0] M_DOT   = 4'd6;
	localparam logic [3:0] M_FLOAT = 4'd7;
	localparam logic [3:0] M_OP2   = 4'd8;
	localparam logic [3:0] M_STR   = 4'd9;

	localparam logic [5:0] K_EOF   = 6'd0;
	localparam logic [5:0] K_ERR   = 6'd1;
	localparam logic [5:0] K_IDENT = 6'd2;
	localparam logic [5:0] K_INT   = 6'd3;
	localparam logic [5:0] K_FLOAT = 6'd4;
	localparam logic [5:0] K_STR   = 6'd5;
	localparam logic [5:0] K_BOOL  = 6'd6;
	localparam logic [5:0] K_DOT   = 6'd31;
	localparam logic [5:0] K_DIV   = 6'd34;

	localparam logic [1:0] E_NONE = 2'd0;
	localparam logic [1:0] E_CHAR = 2'd1;
	localparam logic [1:0] E_STR  = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	// keyword text, first byte in the low byte
	localparam logic [KW_W-1:0] KW_TEXT [KW_COUNT] = '{
		KW_W'("dda"), KW_W'("loob"), KW_W'("elbuod"), KW_W'("esle"),
		KW_W'("taolf"), KW_W'("rof"), KW_W'("fi"), KW_W'("tni"),
		KW_W'("tsil"), KW_W'("gnol"), KW_W'("htgnel"), KW_W'("nruter"),
		KW_W'("evomer"), KW_W'("gnirts"), KW_W'("diov"), KW_W'("elihw"),
		KW_W'("eurt"), KW_W'("eslaf")
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd4, 4'd6, 4'd4, 4'd5, 4'd3, 4'd2, 4'd3, 4'd4,
		4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd5, 4'd4, 4'd5
	};
	localparam logic [5:0] KW_KIND [KW_COUNT] = '{
		6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
		6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, K_BOOL, K_BOOL
	};

	typedef struct packed {
		logic [3:0]         mode;
		logic [KW_W-1:0]    kw;
		logic [7:0]         pend;
		logic [DEPTH_W-1:0] depth;
		logic [31:0]        tstart;
		logic [31:0]        pos;
		logic [15:0]        run;
		logic [23:0]        line;
		logic [15:0]        col;
	} scan_state_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [1:0]  err;
		logic [23:0] line;
		logic [15:0] col;
		logic [31:0] start;
		logic [15:0] len;
		logic        last;
	} tok_t;

	function automatic scan_state_t reset_state();
		scan_state_t s;
		s      = '0;
		s.mode = M_IDLE;
		s.line = 24'd1;
		return s;
	endfunction

	function automatic logic [15:0] inc16(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [23:0] inc24(logic [23:0] v);
		return (v == 24'hFFFFFF) ? v : v + 24'd1;
	endfunction

	function automatic logic [31:0] inc32(logic [31:0] v);
		return (v == 32'hFFFFFFFF) ? v : v + 32'd1;
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_numeral(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [5:0] single_kind(logic [7:0] c);
		logic [5:0] k;
		case (c)
			"(": k = 6'd23;
			")": k = 6'd24;
			"{": k = 6'd25;
			"}": k = 6'd26;
			"[": k = 6'd27;
			"]": k = 6'd28;
			";": k = 6'd29;
			",": k = 6'd30;
			".": k = K_DOT;
			"-": k = 6'd32;
			"+": k = 6'd33;
			"*": k = 6'd35;
			"%": k = 6'd36;
			"!": k = 6'd37;
			"=": k = 6'd39;
			"<": k = 6'd41;
			">": k = 6'd43;
			default: k = K_EOF;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] ident_kind(logic [KW_W-1:0] w, logic [15:0] run);
		logic [5:0] k;
		k = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			if (run == 16'(KW_LEN[i]) && w == KW_TEXT[i])
				k = KW_KIND[i];
		end
		return k;
	endfunction

	function automatic tok_t mk_tok(logic [5:0] kind, logic [1:0] err, logic [23:0] line,
		logic [15:0] col, logic [31:0] start, logic [15:0] len);
		tok_t t;
		t.kind  = kind;
		t.err   = err;
		t.line  = line;
		t.col   = col;
		t.start = start;
		t.len   = len;
		t.last  = 1'b0;
		return t;
	endfunction

endpackage

[rtl/stt_step.sv]
// ----------------------------------------------------------------------------
// stt_step: next-state and token logic for one source byte
// Produces the next scanner state and up to three packed tokens.
// ----------------------------------------------------------------------------
module stt_step (
	input  stt_pkg::scan_state_t st,
	input  logic [7:0]           c,
	input  logic                 eot,
	output stt_pkg::scan_state_t ns,
	output stt_pkg::tok_t        tok [3],
	output logic [1:0]           tok_cnt
);
	import stt_pkg::*;

	tok_t       cand [3];
	logic [2:0] v;
	logic       rescan;
	logic [1:0] n;

	always_comb begin
		ns     = st;
		v      = '0;
		rescan = 1'b0;
		for (int i = 0; i < 3; i++) cand[i] = '0;

		if (eot || c == CH_NUL) begin
			unique case (st.mode)
				M_SLASH: begin
					v[0] = 1'b1;
					cand[0] = mk_tok(K_DIV, E_NONE, ns.line, ns.col, st.tstart, 16'd1);
				end
				M_IDENT: begin
					v[0] = 1'b1;
					cand[0] = mk_tok(ident_kind(st.kw, st.run), E_NONE, ns.line, ns.col,
						st.tstart, st.run);
				end
				M_INT: begin
					v[0] = 1'b1;
					cand[0] = mk_tok(K_INT, E_NONE, ns.line, ns.col, st.tstart, st.run);
				end
				M_DOT: begin
					v[1:0] = 2'b11;
					cand[0] = mk_tok(K_INT, E_NONE, ns.line, ns.col, st.tstart, st.run);
					ns.col = inc16(ns.col);
					cand[1] = mk_tok(K_DOT, E_NONE, ns.line, ns.col, st.pos - 32'd1, 16'd1);
				end
				M_FLOAT: begin
					v[0] = 1'b1;
					cand[0] = mk_tok(K_FLOAT, E_NONE, ns.line, ns.col, st.tstart, st.run);
				end
				M_OP2: begin
					v[0] = 1'b1;
					cand[0] = mk_tok(single_kind(st.pend), E_NONE, ns.line, ns.col,
						st.tstart, 16'd1);
				end
				M_STR: begin
					v[0] = 1'b1;
					cand[0] = mk_tok(K_ERR, E_STR, ns.line, ns.col, st.tstart, st.run);
				end
				default: ;
			endcase
			v[2] = 1'b1;
			cand[2] = mk_tok(K_EOF, E_NONE, ns.line, ns.col, st.pos, 16'd0);
			ns = reset_state();
		end else begin
			unique case (st.mode)
				M_SLASH: begin
					if (c == "/") begin
						ns.col = inc16(ns.col);
						ns.mode = M_LINE;
					end else if (c == "*") begin
						ns.col = inc16(ns.col);
						ns.depth = DEPTH_W'(1);
						ns.pend = 8'd0;
						ns.mode = M_BLOCK;
					end else begin
						v[0] = 1'b1;
						cand[0] = mk_tok(K_DIV, E_NONE, ns.line, ns.col, st.tstart, 16'd1);
						rescan = 1'b1;
					end
				end
				M_LINE: begin
					if (c == CH_LF) rescan = 1'b1;
					else ns.col = inc16(ns.col);
				end
				M_BLOCK: begin
					if (st.pend == "/" && c == "*") begin
						ns.col = inc16(ns.col);
						ns.pend = 8'd0;
						if (st.depth < DEPTH_W'(NEST_DEPTH_MAX)) ns.depth = st.depth + 1'b1;
					end else if (st.pend == "*" && c == "/") begin
						ns.col = inc16(ns.col);
						ns.pend = 8'd0;
						ns.depth = (st.depth != '0) ? st.depth - 1'b1 : st.depth;
						if (ns.depth == '0) ns.mode = M_IDLE;
					end else begin
						if (c == CH_LF) begin
							ns.line = inc24(ns.line);
							ns.col = 16'd1;
						end else begin
							ns.col = inc16(ns.col);
						end
						ns.pend = (c == "/" || c == "*") ? c : 8'd0;
					end
				end
				M_IDENT: begin
					if (is_letter(c) || is_numeral(c)) begin
						if (st.run < 16'(KEYWORD_CHARS))
							ns.kw[{st.run[KW_IDX_W-1:0], 3'b000} +: 8] = c;
						ns.col = inc16(ns.col);
						ns.run = inc16(st.run);
					end else begin
						v[0] = 1'b1;
						cand[0] = mk_tok(ident_kind(st.kw, st.run), E_NONE, ns.line, ns.col,
							st.tstart, st.run);
						rescan = 1'b1;
					end
				end
				M_INT: begin
					if (is_numeral(c)) begin
						ns.col = inc16(ns.col);
						ns.run = inc16(st.run);
					end else if (c == ".") begin
						ns.mode = M_DOT;
					end else begin
						v[0] = 1'b1;
						cand[0] = mk_tok(K_INT, E_NONE, ns.line, ns.col, st.tstart, st.run);
						rescan = 1'b1;
					end
				end
				M_DOT: begin
					if (is_numeral(c)) begin
						ns.col = inc16(inc16(st.col));
						ns.run = inc16(inc16(st.run));
						ns.mode = M_FLOAT;
					end else begin
						v[1:0] = 2'b11;
						cand[0] = mk_tok(K_INT, E_NONE, ns.line, ns.col, st.tstart, st.run);
						ns.col = inc16(ns.col);
						cand[1] = mk_tok(K_DOT, E_NONE, ns.line, ns.col, st.pos - 32'd1, 16'd1);
						rescan = 1'b1;
					end
				end
				M_FLOAT: begin
					if (is_numeral(c)) begin
						ns.col = inc16(ns.col);
						ns.run = inc16(st.run);
					end else begin
						v[0] = 1'b1;
						cand[0] = mk_tok(K_FLOAT, E_NONE, ns.line, ns.col, st.tstart, st.run);
						rescan = 1'b1;
					end
				end
				M_OP2: begin
					if (c == "=") begin
						ns.col = inc16(ns.col);
						v[0] = 1'b1;
						cand[0] = mk_tok(single_kind(st.pend) + 6'd1, E_NONE, ns.line, ns.col,
							st.tstart, 16'd2);
						ns.mode = M_IDLE;
					end else begin
						v[0] = 1'b1;
						cand[0] = mk_tok(single_kind(st.pend), E_NONE, ns.line, ns.col,
							st.tstart, 16'd1);
						rescan = 1'b1;
					end
				end
				M_STR: begin
					if (st.pend == CH_BSL && c == CH_QUOTE) begin
						ns.col = inc16(ns.col);
						ns.run = inc16(st.run);
						ns.pend = 8'd0;
					end else if (c == CH_QUOTE) begin
						ns.col = inc16(ns.col);
						v[0] = 1'b1;
						cand[0] = mk_tok(K_STR, E_NONE, ns.line, ns.col, st.tstart, st.run);
						ns.mode = M_IDLE;
					end else begin
						if (c == CH_LF) begin
							ns.line = inc24(ns.line);
							ns.col = 16'd1;
						end else begin
							ns.col = inc16(ns.col);
						end
						ns.run = inc16(st.run);
						ns.pend = (c == CH_BSL) ? c : 8'd0;
					end
				end
				default: rescan = 1'b1;
			endcase

			if (rescan) begin
				ns.mode = M_IDLE;
				if (c == CH_SPACE || c == CH_CR || c == CH_TAB) begin
					ns.col = inc16(ns.col);
				end else if (c == CH_LF) begin
					ns.line = inc24(ns.line);
					ns.col = 16'd1;
				end else if (c == "/") begin
					ns.tstart = st.pos;
					ns.run = 16'd0;
					ns.col = inc16(ns.col);
					ns.mode = M_SLASH;
				end else if (is_letter(c)) begin
					ns.tstart = st.pos;
					ns.run = 16'd1;
					ns.col = inc16(ns.col);
					ns.kw = KW_W'(c);
					ns.mode = M_IDENT;
				end else if (is_numeral(c)) begin
					ns.tstart = st.pos;
					ns.run = 16'd1;
					ns.col = inc16(ns.col);
					ns.mode = M_INT;
				end else if (c == "!" || c == "=" || c == "<" || c == ">") begin
					ns.tstart = st.pos;
					ns.run = 16'd0;
					ns.col = inc16(ns.col);
					ns.pend = c;
					ns.mode = M_OP2;
				end else if (c == CH_QUOTE) begin
					ns.tstart = st.pos;
					ns.run = 16'd0;
					ns.col = inc16(ns.col);
					ns.pend = 8'd0;
					ns.mode = M_STR;
				end else begin
					ns.col = inc16(ns.col);
					v[2] = 1'b1;
					if (single_kind(c) != K_EOF)
						cand[2] = mk_tok(single_kind(c), E_NONE, ns.line, ns.col, st.pos, 16'd1);
					else
						cand[2] = mk_tok(K_ERR, E_CHAR, ns.line, ns.col, st.pos, 16'd1);
				end
			end
			ns.pos = inc32(st.pos);
		end
	end

	// pack requests in order, flag the final one
	always_comb begin
		n = 2'd0;
		for (int i = 0; i < 3; i++) tok[i] = cand[i];
		for (int i = 0; i < 3; i++) begin
			if (v[i]) begin
				tok[n] = cand[i];
				n = n + 2'd1;
			end
		end
		if (n != 2'd0) tok[n - 2'd1].last = 1'b1;
		tok_cnt = n;
	end

endmodule

[rtl/stt_queue.sv]
// ----------------------------------------------------------------------------
// stt_queue: token output queue
// Takes up to three tokens per cycle, delivers one per cycle while pop is high.
// ----------------------------------------------------------------------------
module stt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_cnt,
	input  stt_pkg::tok_t push_tok [3],
	input  logic          pop,
	output stt_pkg::tok_t head,
	output logic          not_empty,
	output logic          room
);
	import stt_pkg::*;

	localparam int DEPTH = 8;
	localparam int PTR_W = $clog2(DEPTH);

	tok_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [PTR_W:0]   count_q;

	assign not_empty = count_q != '0;
	assign room      = count_q <= (PTR_W + 1)'(DEPTH - 3);
	assign head      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < push_cnt)
				mem_q[PTR_W'(wptr_q + PTR_W'(i))] <= push_tok[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= PTR_W'(wptr_q + PTR_W'(push_cnt));
			rptr_q  <= rptr_q + PTR_W'(pop);
			count_q <= count_q + (PTR_W + 1)'(push_cnt) - (PTR_W + 1)'(pop);
		end
	end

endmodule

[rtl/source_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming lexer, one source byte per request
// Input register, combinational scan logic, 8-entry token queue.
// ----------------------------------------------------------------------------
// A byte is registered in the input stage, then scanned and written into the
// token queue, whose head drives the output. Throughput: one byte per cycle
// while the queue holds 5 tokens or fewer; tokens leave it one at a time.
// Reset: asynchronous, clears scanner to idle, line 1, column 0, queue empty.
module source_text_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [7:0]  char_byte,
	input  logic        end_of_text,
	output logic        token_valid,
	input  logic        token_ready,
	output logic [5:0]  token_kind,
	output logic [1:0]  error_code,
	output logic [23:0] end_line,
	output logic [15:0] end_column,
	output logic [31:0] start_offset,
	output logic [15:0] lexeme_length,
	output logic        last_of_run
);
	import stt_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eot_s1;
	scan_state_t state_q;
	scan_state_t state_nxt;
	tok_t        toks [3];
	logic [1:0]  tok_cnt;
	logic        room;
	logic        fire;
	tok_t        head;

	assign fire       = valid_s1 && room;
	assign char_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= reset_state();
		end else begin
			if (char_ready) valid_s1 <= char_valid;
			if (fire) state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			byte_s1 <= char_byte;
			eot_s1  <= end_of_text;
		end
	end

	stt_step u_step (
		.st      (state_q),
		.c       (byte_s1),
		.eot     (eot_s1),
		.ns      (state_nxt),
		.tok     (toks),
		.tok_cnt (tok_cnt)
	);

	stt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (fire ? tok_cnt : 2'd0),
		.push_tok  (toks),
		.pop       (token_valid && token_ready),
		.head      (head),
		.not_empty (token_valid),
		.room      (room)
	);

	assign token_kind    = head.kind;
	assign error_code    = head.err;
	assign end_line      = head.line;
	assign end_column    = head.col;
	assign start_offset  = head.start;
	assign lexeme_length = head.len;
	assign last_of_run   = head.last;

endmodule

[rtl/stt_checker.sv]
// ----------------------------------------------------------------------------
// stt_checker: port-level checks for the tokenizer
// Watches the token channel for handshake and field consistency.
// ----------------------------------------------------------------------------
module stt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        token_valid,
	input logic        token_ready,
	input logic [5:0]  token_kind,
	input logic [1:0]  error_code,
	input logic [23:0] end_line,
	input logic        last_of_run
);
	import stt_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_ready |=> token_valid && $stable(token_kind))
		else $error("token dropped while stalled");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind == K_EOF |-> last_of_run)
		else $error("EOF not last of run");

	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && error_code != E_NONE |-> token_kind == K_ERR)
		else $error("error code on non-error token");

	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> end_line != 24'd0)
		else $error("line count zero");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.token_valid (token_valid),
	.token_ready (token_ready),
	.token_kind  (token_kind),
	.error_code  (error_code),
	.end_line    (end_line),
	.last_of_run (last_of_run)
);

[tb/tb_token_checker.sv]
// ----------------------------------------------------------------------------
// tb_token_checker: token stream predictor and scoreboard
// Watches the byte and token channels, predicts the tokens for every
// accepted byte and compares them field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_token_checker
	import stt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	input  logic        char_ready,
	input  logic [7:0]  char_byte,
	input  logic        end_of_text,
	input  logic        token_valid,
	input  logic        token_ready,
	input  logic [5:0]  token_kind,
	input  logic [1:0]  error_code,
	input  logic [23:0] end_line,
	input  logic [15:0] end_column,
	input  logic [31:0] start_offset,
	input  logic [15:0] lexeme_length,
	input  logic        last_of_run,
	output int          fail_count,
	output int          tokens_pending
);

	localparam logic [5:0] P_LPAR = 6'd23, P_RPAR = 6'd24, P_LBRC = 6'd25, P_RBRC = 6'd26;
	localparam logic [5:0] P_LBRK = 6'd27, P_RBRK = 6'd28, P_SEMI = 6'd29, P_COMMA = 6'd30;
	localparam logic [5:0] P_MINUS = 6'd32, P_PLUS = 6'd33, P_STAR = 6'd35, P_PCT = 6'd36;
	localparam logic [5:0] P_NOT = 6'd37, P_ASSIGN = 6'd39, P_LT = 6'd41, P_GT = 6'd43;

	localparam string WORDS [KW_COUNT] = '{"add", "bool", "double", "else", "float", "for",
		"if", "int", "list", "long", "length", "return", "remove", "string", "void",
		"while", "true", "false"};
	localparam logic [5:0] WORD_KIND [KW_COUNT] = '{6'd7, 6'd8, 6'd9, 6'd10, 6'd11,
		6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22,
		K_BOOL, K_BOOL};

	logic [3:0]  mode;
	logic [47:0] window;
	logic [7:0]  pend;
	int          depth;
	logic [31:0] tok_start, pos, here;
	logic [15:0] run, col;
	logic [23:0] line;
	tok_t        step_toks [$];
	tok_t        expected_tokens [$];

	assign tokens_pending = expected_tokens.size();

	function automatic bit letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [5:0] punct_kind(logic [7:0] c);
		case (c)
			"(": return P_LPAR;
			")": return P_RPAR;
			"{": return P_LBRC;
			"}": return P_RBRC;
			"[": return P_LBRK;
			"]": return P_RBRK;
			";": return P_SEMI;
			",": return P_COMMA;
			".": return K_DOT;
			"-": return P_MINUS;
			"+": return P_PLUS;
			"*": return P_STAR;
			"%": return P_PCT;
			"!": return P_NOT;
			"=": return P_ASSIGN;
			"<": return P_LT;
			">": return P_GT;
			default: return K_EOF;
		endcase
	endfunction

	function automatic logic [5:0] word_kind();
		bit same;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (WORDS[k].len() != run || WORDS[k].len() > KEYWORD_CHARS)
				continue;
			same = 1;
			for (int i = 0; i < WORDS[k].len(); i++)
				if (window[8*i +: 8] != WORDS[k][i])
					same = 0;
			if (same)
				return WORD_KIND[k];
		end
		return K_IDENT;
	endfunction

	function automatic void clear_scan();
		mode = M_IDLE;
		window = '0;
		pend = '0;
		depth = 0;
		tok_start = '0;
		pos = '0;
		run = '0;
		line = 24'd1;
		col = '0;
	endfunction

	function automatic void put(logic [5:0] k, logic [1:0] e, logic [31:0] s, logic [15:0] n);
		tok_t t;
		if (step_toks.size() >= 3)
			return;
		t.kind = k;
		t.err = e;
		t.line = line;
		t.col = col;
		t.start = s;
		t.len = n;
		t.last = 1'b0;
		step_toks.push_back(t);
	endfunction

	function automatic void bump_col();
		if (col != 16'hFFFF)
			col++;
	endfunction

	function automatic void bump_run();
		if (run != 16'hFFFF)
			run++;
	endfunction

	function automatic void new_line();
		if (line != 24'hFFFFFF)
			line++;
		col = '0;
		bump_col();
	endfunction

	function automatic void int_then_dot();
		put(K_INT, E_NONE, tok_start, run);
		bump_col();
		put(K_DOT, E_NONE, here - 1, 16'd1);
	endfunction

	function automatic void scan_fresh(logic [7:0] c);
		tok_start = here;
		run = '0;
		bump_col();
		if (c == "/")
			mode = M_SLASH;
		else if (letter(c)) begin
			bump_run();
			window = 48'(c);
			mode = M_IDENT;
		end else if (digit(c)) begin
			bump_run();
			mode = M_INT;
		end else if (c == "!" || c == "=" || c == "<" || c == ">") begin
			pend = c;
			mode = M_OP2;
		end else if (c == CH_QUOTE) begin
			pend = '0;
			mode = M_STR;
		end else if (punct_kind(c) != K_EOF)
			put(punct_kind(c), E_NONE, here, 16'd1);
		else
			put(K_ERR, E_CHAR, here, 16'd1);
	endfunction

	function automatic void scan(logic [7:0] c);
		bit done;
		done = 0;
		while (!done) begin
			done = 1;
			case (mode)
				M_SLASH: begin
					if (c == "/") begin
						bump_col();
						mode = M_LINE;
					end else if (c == "*") begin
						bump_col();
						depth = 1;
						pend = '0;
						mode = M_BLOCK;
					end else begin
						put(K_DIV, E_NONE, tok_start, 16'd1);
						done = 0;
					end
				end
				M_LINE: begin
					if (c == CH_LF)
						done = 0;
					else
						bump_col();
				end
				M_BLOCK: begin
					if (pend == "/" && c == "*") begin
						bump_col();
						pend = '0;
						if (depth < NEST_DEPTH_MAX)
							depth++;
					end else if (pend == "*" && c == "/") begin
						bump_col();
						pend = '0;
						if (depth > 0)
							depth--;
						if (depth == 0)
							mode = M_IDLE;
					end else begin
						if (c == CH_LF)
							new_line();
						else
							bump_col();
						pend = (c == "/" || c == "*") ? c : 8'd0;
					end
				end
				M_IDENT: begin
					if (letter(c) || digit(c)) begin
						if (run < KEYWORD_CHARS)
							window[8*run +: 8] = c;
						bump_col();
						bump_run();
					end else begin
						put(word_kind(), E_NONE, tok_start, run);
						done = 0;
					end
				end
				M_INT: begin
					if (digit(c)) begin
						bump_col();
						bump_run();
					end else if (c == ".")
						mode = M_DOT;
					else begin
						put(K_INT, E_NONE, tok_start, run);
						done = 0;
					end
				end
				M_DOT: begin
					if (digit(c)) begin
						bump_col();
						bump_run();
						bump_col();
						bump_run();
						mode = M_FLOAT;
					end else begin
						int_then_dot();
						done = 0;
					end
				end
				M_FLOAT: begin
					if (digit(c)) begin
						bump_col();
						bump_run();
					end else begin
						put(K_FLOAT, E_NONE, tok_start, run);
						done = 0;
					end
				end
				M_OP2: begin
					if (c == "=") begin
						bump_col();
						put(punct_kind(pend) + 6'd1, E_NONE, tok_start, 16'd2);
						mode = M_IDLE;
					end else begin
						put(punct_kind(pend), E_NONE, tok_start, 16'd1);
						done = 0;
					end
				end
				M_STR: begin
					if (pend == CH_BSL && c == CH_QUOTE) begin
						bump_col();
						bump_run();
						pend = '0;
					end else if (c == CH_QUOTE) begin
						bump_col();
						put(K_STR, E_NONE, tok_start, run);
						mode = M_IDLE;
					end else begin
						if (c == CH_LF)
							new_line();
						else
							bump_col();
						bump_run();
						pend = (c == CH_BSL) ? c : 8'd0;
					end
				end
				default: begin
					mode = M_IDLE;
					if (c == CH_SPACE || c == CH_CR || c == CH_TAB)
						bump_col();
					else if (c == CH_LF)
						new_line();
					else
						scan_fresh(c);
				end
			endcase
			if (!done)
				mode = M_IDLE;
		end
	endfunction

	function automatic void predict(logic [7:0] c, logic eot);
		step_toks.delete();
		here = pos;
		if (eot || c == CH_NUL) begin
			case (mode)
				M_SLASH: put(K_DIV, E_NONE, tok_start, 16'd1);
				M_IDENT: put(word_kind(), E_NONE, tok_start, run);
				M_INT:   put(K_INT, E_NONE, tok_start, run);
				M_DOT:   int_then_dot();
				M_FLOAT: put(K_FLOAT, E_NONE, tok_start, run);
				M_OP2:   put(punct_kind(pend), E_NONE, tok_start, 16'd1);
				M_STR:   put(K_ERR, E_STR, tok_start, run);
				default: ;
			endcase
			put(K_EOF, E_NONE, pos, 16'd0);
			clear_scan();
		end else begin
			scan(c);
			if (pos != 32'hFFFFFFFF)
				pos++;
		end
		if (step_toks.size() > 0)
			step_toks[step_toks.size() - 1].last = 1'b1;
		foreach (step_toks[i])
			expected_tokens.push_back(step_toks[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tok_t exp_t;
		if (!arst_n) begin
			clear_scan();
			expected_tokens.delete();
			fail_count <= 0;
		end else begin
			if (char_valid && char_ready)
				predict(char_byte, end_of_text);
			if (token_valid && token_ready) begin
				if (expected_tokens.size() == 0) begin
					$error("unexpected token kind %0d at offset %0d", token_kind, start_offset);
					fail_count <= fail_count + 1;
				end else begin
					exp_t = expected_tokens.pop_front();
					if ({token_kind, error_code, end_line, end_column, start_offset,
						lexeme_length, last_of_run} != exp_t) begin
						fail_count <= fail_count + 1;
						if (token_kind != exp_t.kind)
							$error("token_kind exp %0d got %0d", exp_t.kind, token_kind);
						if (error_code != exp_t.err)
							$error("error_code exp %0d got %0d", exp_t.err, error_code);
						if (end_line != exp_t.line)
							$error("end_line exp %0d got %0d", exp_t.line, end_line);
						if (end_column != exp_t.col)
							$error("end_column exp %0d got %0d", exp_t.col, end_column);
						if (start_offset != exp_t.start)
							$error("start_offset exp %0d got %0d", exp_t.start, start_offset);
						if (lexeme_length != exp_t.len)
							$error("lexeme_length exp %0d got %0d", exp_t.len, lexeme_length);
						if (last_of_run != exp_t.last)
							$error("last_of_run exp %0d got %0d", exp_t.last, last_of_run);
					end
				end
			end
		end
	end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: tokenizer testbench
// Feeds directed source fragments and random token sequences with noise,
// random request gaps and output stalls; the checker scores the tokens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import stt_pkg::*;

	localparam int CYCLE_LIMIT = 300000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        char_valid = 0;
	logic        char_ready;
	logic [7:0]  char_byte = 8'h20;
	logic        end_of_text = 0;
	logic        token_valid;
	logic        token_ready = 0;
	logic [5:0]  token_kind;
	logic [1:0]  error_code;
	logic [23:0] end_line;
	logic [15:0] end_column;
	logic [31:0] start_offset;
	logic [15:0] lexeme_length;
	logic        last_of_run;
	int          fail_count, tokens_pending;
	int          cycles = 0, sent = 0, hold = 0;
	logic        byte_taken = 0, token_taken = 0;
	bit          calm = 0;

	always #5 clk = ~clk;

	source_text_tokenizer dut (.*);

	tb_token_checker checker_i (.*);

	function automatic int draw_gap();
		if (calm || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	always @(posedge clk) begin
		byte_taken <= char_valid && char_ready;
		token_taken <= token_valid && token_ready;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		int s;
		s = hold;
		if (token_taken)
			s = draw_gap();
		token_ready <= (s == 0);
		hold <= (s > 0) ? s - 1 : 0;
	end

	task automatic send(logic [7:0] c, logic eot);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			char_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		char_valid <= 1;
		char_byte <= c;
		end_of_text <= eot;
		@(negedge clk);
		while (!byte_taken)
			@(negedge clk);
		sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send(s[i], 0);
	endtask

	task automatic drain();
		char_valid <= 0;
		@(negedge clk);
		while (tokens_pending != 0)
			@(negedge clk);
	endtask

	function automatic string rand_word();
		string w;
		string kws [18] = '{"add", "bool", "double", "else", "float", "for", "if", "int",
			"list", "long", "length", "return", "remove", "string", "void", "while",
			"true", "false"};
		string abc = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
		if ($urandom_range(0, 1))
			return kws[$urandom_range(0, 17)];
		w = "";
		w = {w, string'(abc[$urandom_range(0, 52)])};
		repeat ($urandom_range(0, 8))
			w = {w, string'(abc[$urandom_range(0, 62)])};
		return w;
	endfunction

	function automatic string rand_digits(int n);
		string d = "";
		repeat (n)
			d = {d, string'(8'("0") + 8'($urandom_range(0, 9)))};
		return d;
	endfunction

	function automatic string rand_piece();
		string ops [20] = '{"(", ")", "{", "}", "[", "]", ";", ",", ".", "-", "+", "*",
			"/", "%", "!", "!=", "=", "==", "<=", ">="};
		string ws [4] = '{" ", "\n", "\t", "\r"};
		case ($urandom_range(0, 11))
			0, 1: return rand_word();
			2: return rand_digits($urandom_range(1, 4));
			3: return {rand_digits($urandom_range(1, 3)), ".", rand_digits($urandom_range(1, 3))};
			4: return {rand_digits(2), ".", ops[$urandom_range(0, 13)]};
			5, 6: return ops[$urandom_range(0, 19)];
			7: return {"\"", rand_word(), "\\\"", ws[$urandom_range(0, 1)], "\""};
			8: return {"// ", rand_word(), "\n"};
			9: return {"/* a /* ", rand_word(), " */ */"};
			10: return string'(8'($urandom_range(1, 255)));
			default: return ws[$urandom_range(0, 3)];
		endcase
	endfunction

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1;
		calm = 1;
		send_text("if x_9 >= 42.5 != \"a\\\"b\n\" <q> = ==!(){}[];,-+*%/ 7.x 3.");
		send(8'h00, 0);
		send_text("add bool double else float for int list long length return remove");
		send_text(" string void while true false doubles AZaz_ 8'@#");
		send(8'hFF, 0);
		send(8'h80, 0);
		send_text("/");
		send(8'h55, 1);
		send_text("12.");
		send(8'h00, 1);
		send_text("\"open\\");
		send(8'h00, 1);
		for (int i = 0; i < 17; i++)
			send_text("/*");
		send_text("*/*/ x");
		send(8'h00, 1);
		send_text("/* open <");
		send(8'h00, 1);
		send_text("< a >");
		send(8'h00, 1);
		drain();
		calm = 0;
		while (sent < 280) begin
			if ($urandom_range(0, 9) == 0)
				calm = ~calm;
			if ($urandom_range(0, 7) == 0)
				send(8'($urandom_range(1, 255)), 0);
			else
				send_text(rand_piece());
			if ($urandom_range(0, 14) == 0)
				send(8'($urandom_range(0, 255)), 1);
			if (sent > 250 && sent < 260)
				drain();
		end
		send(8'h00, 1);
		char_valid <= 0;
		drain();
		repeat (30) @(negedge clk);
		if (fail_count == 0 && tokens_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
